FILE: sv/sum_checked_frame_relay_unit_assert.svh
// Assertion macros shared by the frame relay RTL
`ifndef SUM_CHECKED_FRAME_RELAY_UNIT_ASSERT_SVH
`define SUM_CHECKED_FRAME_RELAY_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SCFR_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("scfr assertion failed");

// next-cycle implication, disabled during reset
`define SCFR_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("scfr assertion failed");

`endif

FILE: sv/scfr_pkg.sv
// Package: constants and types of the frame relay
package scfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int CFG_INDEX_W = 8;
  localparam int WIN_DEPTH   = 6;
  localparam int RELAY_LEN   = 5;
  localparam int RELAY_DEPTH = 2 * RELAY_LEN;
  localparam int TAIL_BASE   = RELAY_DEPTH - RELAY_LEN;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h54;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h70;

  localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER   = 8'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } relay_item_t;

  typedef struct packed {
    logic valid;
    logic move;
  } relay_stat_t;

endpackage

FILE: sv/scfr_win_cell.sv
// One byte cell of the receive window shift chain
module scfr_win_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift,
  input  logic                          clear,
  input  logic [scfr_pkg::BYTE_W-1:0]   d,
  output logic [scfr_pkg::BYTE_W-1:0]   q
);

  logic [scfr_pkg::BYTE_W-1:0] q_next;

  always_comb begin
    q_next = q;
    if (clear) begin
      q_next = '0;
    end else if (shift) begin
      q_next = d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= q_next;
    end
  end

endmodule

FILE: sv/scfr_relay_cell.sv
// One cell of the output relay chain: holds an item and passes it toward the head
module scfr_relay_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  scfr_pkg::relay_item_t load_item,
  input  scfr_pkg::relay_item_t up_item,
  input  scfr_pkg::relay_stat_t up_stat,
  input  scfr_pkg::relay_stat_t down_stat,
  output scfr_pkg::relay_stat_t stat,
  output scfr_pkg::relay_item_t item
);

  logic                  valid;
  logic                  valid_next;
  logic                  move;
  scfr_pkg::relay_item_t item_next;

  assign move       = valid & (~down_stat.valid | down_stat.move);
  assign stat.valid = valid;
  assign stat.move  = move;

  always_comb begin
    valid_next = load | (valid & ~move) | up_stat.move;
    item_next  = item;
    if (load) begin
      item_next = load_item;
    end else if (up_stat.move) begin
      item_next = up_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
  end

endmodule

FILE: sv/sum_checked_frame_relay_unit.sv
// Top level: sliding-window frame checker with a relay chain for the output bytes
//
// Usage:
//   rx_byte enters on in_valid/in_ready, one byte per cycle. Each accepted byte
//   shifts a six-cell window; with it the newest seven bytes are checked for a
//   frame (start marker, sum-checked payload, end marker).
//   An accepted frame clears the window and loads five items into the tail of a
//   ten-cell relay chain: checksum, value low, value high, sensor id, device id
//   (frame_last set). Items walk one cell per cycle toward the head unless a
//   stalled receiver holds the chain, and leave on out_valid/out_ready. The
//   first output item is valid once the checksum reaches the head; the five
//   items then follow back to back while out_ready is high. Throughput: one
//   byte per cycle while in_ready is high; after a frame it stays low until the
//   tail is free, and a stalled receiver keeps the tail full until items drain.
//   cfg_index 0 writes start_marker, 1 writes end_marker; other indexes are
//   ignored. cfg_ready is always high.
//   Reset (rst, synchronous) clears the window to zeros, empties the chain and
//   restores markers to 0x54 and 0x70.
module sum_checked_frame_relay_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [scfr_pkg::BYTE_W-1:0]        rx_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [scfr_pkg::BYTE_W-1:0]        tx_byte,
  output logic                               frame_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [scfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [scfr_pkg::BYTE_W-1:0]        cfg_data
);

  logic [scfr_pkg::BYTE_W-1:0] start_marker;
  logic [scfr_pkg::BYTE_W-1:0] end_marker;
  logic [scfr_pkg::BYTE_W-1:0] win [scfr_pkg::WIN_DEPTH];
  logic [scfr_pkg::BYTE_W-1:0] sum;
  logic                        in_fire;
  logic                        match;
  logic                        frame_fire;
  logic                        tail_busy;

  scfr_pkg::relay_item_t load_item [scfr_pkg::RELAY_LEN];
  scfr_pkg::relay_item_t items     [scfr_pkg::RELAY_DEPTH];
  scfr_pkg::relay_stat_t stats     [scfr_pkg::RELAY_DEPTH];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= scfr_pkg::START_MARKER_RST;
      end_marker   <= scfr_pkg::END_MARKER_RST;
    end else if (cfg_valid) begin
      if (cfg_index == scfr_pkg::REG_START_MARKER) begin
        start_marker <= cfg_data;
      end
      if (cfg_index == scfr_pkg::REG_END_MARKER) begin
        end_marker <= cfg_data;
      end
    end
  end

  assign in_fire    = in_valid & in_ready;
  assign sum        = win[4] + win[3] + win[2] + win[1];
  assign match      = (win[5] == start_marker) && (rx_byte == end_marker) && (win[0] == sum);
  assign frame_fire = in_fire & match;

  always_comb begin
    tail_busy = 1'b0;
    for (int k = scfr_pkg::TAIL_BASE; k < scfr_pkg::RELAY_DEPTH; k++) begin
      tail_busy = tail_busy | stats[k].valid;
    end
  end

  assign in_ready = ~tail_busy;

  for (genvar i = 0; i < scfr_pkg::WIN_DEPTH; i++) begin : g_win
    if (i == 0) begin : g_head
      scfr_win_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (in_fire),
        .clear (frame_fire),
        .d     (rx_byte),
        .q     (win[i])
      );
    end else begin : g_body
      scfr_win_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (in_fire),
        .clear (frame_fire),
        .d     (win[i-1]),
        .q     (win[i])
      );
    end
  end

  // checksum goes nearest the head, device id last
  assign load_item[0] = '{data: sum,    last: 1'b0};
  assign load_item[1] = '{data: win[1], last: 1'b0};
  assign load_item[2] = '{data: win[2], last: 1'b0};
  assign load_item[3] = '{data: win[3], last: 1'b0};
  assign load_item[4] = '{data: win[4], last: 1'b1};

  for (genvar j = 0; j < scfr_pkg::RELAY_DEPTH; j++) begin : g_relay
    scfr_pkg::relay_stat_t down_stat;
    scfr_pkg::relay_stat_t up_stat;
    scfr_pkg::relay_item_t up_item;
    scfr_pkg::relay_item_t cell_load_item;
    logic                  cell_load;

    if (j == 0) begin : g_down_head
      assign down_stat = '{valid: ~out_ready, move: 1'b0};
    end else begin : g_down_body
      assign down_stat = stats[j-1];
    end

    if (j == scfr_pkg::RELAY_DEPTH - 1) begin : g_up_tail
      assign up_stat = '0;
      assign up_item = '0;
    end else begin : g_up_body
      assign up_stat = stats[j+1];
      assign up_item = items[j+1];
    end

    if (j >= scfr_pkg::TAIL_BASE) begin : g_load
      assign cell_load      = frame_fire;
      assign cell_load_item = load_item[j - scfr_pkg::TAIL_BASE];
    end else begin : g_noload
      assign cell_load      = 1'b0;
      assign cell_load_item = '0;
    end

    scfr_relay_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (cell_load),
      .load_item (cell_load_item),
      .up_item   (up_item),
      .up_stat   (up_stat),
      .down_stat (down_stat),
      .stat      (stats[j]),
      .item      (items[j])
    );
  end

  assign out_valid  = stats[0].valid;
  assign tx_byte    = items[0].data;
  assign frame_last = items[0].last;

`include "sum_checked_frame_relay_unit_assert.svh"

  `SCFR_ASSERT_NXT(a_frame_loads_tail, clk, rst, frame_fire, stats[scfr_pkg::RELAY_DEPTH-1].valid && items[scfr_pkg::RELAY_DEPTH-1].last)
  `SCFR_ASSERT_NXT(a_window_cleared, clk, rst, frame_fire, win[scfr_pkg::WIN_DEPTH-1] == '0 && win[0] == '0)
  `SCFR_ASSERT_NXT(a_frame_contiguous, clk, rst, out_valid && out_ready && !frame_last, out_valid)

endmodule
